@@ rtl/core/tfn_pkg.sv @@
// Shared types and constants for the triangle face normal block.
`timescale 1ns / 1ps

package tfn_pkg;

    localparam int COORD_WIDTH  = 24;
    localparam int PRE_SHIFT    = (COORD_WIDTH > 30) ? COORD_WIDTH - 30 : 0;
    localparam int DIFF_WIDTH   = COORD_WIDTH + 1 - PRE_SHIFT;
    localparam int PROD_WIDTH   = 2 * DIFF_WIDTH;
    localparam int CROSS_WIDTH  = PROD_WIDTH + 1;
    localparam int NORM_WIDTH   = 30;
    localparam int OUT_WIDTH    = 16;
    localparam int QUEUE_DEPTH  = 4;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] vertex_a_x;
        logic signed [COORD_WIDTH-1:0] vertex_a_y;
        logic signed [COORD_WIDTH-1:0] vertex_a_z;
        logic signed [COORD_WIDTH-1:0] vertex_b_x;
        logic signed [COORD_WIDTH-1:0] vertex_b_y;
        logic signed [COORD_WIDTH-1:0] vertex_b_z;
        logic signed [COORD_WIDTH-1:0] vertex_c_x;
        logic signed [COORD_WIDTH-1:0] vertex_c_y;
        logic signed [COORD_WIDTH-1:0] vertex_c_z;
        logic                          last_triangle;
    } tri_in_t;

    typedef struct packed {
        logic signed [OUT_WIDTH-1:0] normal_x;
        logic signed [OUT_WIDTH-1:0] normal_y;
        logic signed [OUT_WIDTH-1:0] normal_z;
        logic                        degenerate;
        logic                        last_normal;
    } tri_out_t;

    // Cross product handed from the front end to the normalizer.
    typedef struct packed {
        logic [2:0][CROSS_WIDTH-1:0] prod;
        logic                        last;
    } cross_t;

endpackage

@@ rtl/core/tfn_front.sv @@
// Front end: edge vectors and cross product, three register stages.
`timescale 1ns / 1ps

module tfn_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  tfn_pkg::tri_in_t in_data,
    output logic             in_stall,
    input  logic             q_full,
    output logic             push,
    output tfn_pkg::cross_t  push_data
);
    import tfn_pkg::*;

    logic                         fe;
    logic                         v1_reg, v2_reg, v3_reg;
    logic signed [COORD_WIDTH:0]  du_full [3];
    logic signed [COORD_WIDTH:0]  dv_full [3];
    logic signed [DIFF_WIDTH-1:0] du_reg  [3];
    logic signed [DIFF_WIDTH-1:0] dv_reg  [3];
    logic signed [PROD_WIDTH-1:0] p_reg   [6];
    logic                         last1_reg, last2_reg, last3_reg;
    logic [2:0][CROSS_WIDTH-1:0]  cross_reg;

    // The stages move together whenever the queue can take one more item.
    assign fe       = !q_full;
    assign in_stall = q_full;
    assign push     = fe && v3_reg;

    always_comb
    begin
        du_full[0] = {in_data.vertex_a_x[COORD_WIDTH-1], in_data.vertex_a_x}
                   - {in_data.vertex_b_x[COORD_WIDTH-1], in_data.vertex_b_x};
        du_full[1] = {in_data.vertex_a_y[COORD_WIDTH-1], in_data.vertex_a_y}
                   - {in_data.vertex_b_y[COORD_WIDTH-1], in_data.vertex_b_y};
        du_full[2] = {in_data.vertex_a_z[COORD_WIDTH-1], in_data.vertex_a_z}
                   - {in_data.vertex_b_z[COORD_WIDTH-1], in_data.vertex_b_z};
        dv_full[0] = {in_data.vertex_a_x[COORD_WIDTH-1], in_data.vertex_a_x}
                   - {in_data.vertex_c_x[COORD_WIDTH-1], in_data.vertex_c_x};
        dv_full[1] = {in_data.vertex_a_y[COORD_WIDTH-1], in_data.vertex_a_y}
                   - {in_data.vertex_c_y[COORD_WIDTH-1], in_data.vertex_c_y};
        dv_full[2] = {in_data.vertex_a_z[COORD_WIDTH-1], in_data.vertex_a_z}
                   - {in_data.vertex_c_z[COORD_WIDTH-1], in_data.vertex_c_z};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (fe)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fe)
        begin
            // Wide coordinates are floored down so every product fits.
            for (int i = 0; i < 3; i++)
            begin
                du_reg[i] <= DIFF_WIDTH'(du_full[i] >>> PRE_SHIFT);
                dv_reg[i] <= DIFF_WIDTH'(dv_full[i] >>> PRE_SHIFT);
            end
            last1_reg <= in_data.last_triangle;

            p_reg[0]  <= du_reg[1] * dv_reg[2];
            p_reg[1]  <= du_reg[2] * dv_reg[1];
            p_reg[2]  <= du_reg[2] * dv_reg[0];
            p_reg[3]  <= du_reg[0] * dv_reg[2];
            p_reg[4]  <= du_reg[0] * dv_reg[1];
            p_reg[5]  <= du_reg[1] * dv_reg[0];
            last2_reg <= last1_reg;

            cross_reg[0] <= CROSS_WIDTH'(p_reg[0]) - CROSS_WIDTH'(p_reg[1]);
            cross_reg[1] <= CROSS_WIDTH'(p_reg[2]) - CROSS_WIDTH'(p_reg[3]);
            cross_reg[2] <= CROSS_WIDTH'(p_reg[4]) - CROSS_WIDTH'(p_reg[5]);
            last3_reg    <= last2_reg;
        end
    end

    assign push_data.prod = cross_reg;
    assign push_data.last = last3_reg;

endmodule

@@ rtl/core/tfn_queue.sv @@
// Small FIFO between the front end and the normalizer.
`timescale 1ns / 1ps

module tfn_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  tfn_pkg::cross_t push_data,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output tfn_pkg::cross_t head
);
    import tfn_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    cross_t          mem_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_reg, rd_reg;
    logic [CW-1:0]   count_reg;

    assign full       = (count_reg == CW'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= (wr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            if (pop)
                rd_reg <= (rd_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_data;
    end

endmodule

@@ rtl/core/tfn_back.sv @@
// Back end: normalize, square, pipelined square root and division to unit length.
`timescale 1ns / 1ps

module tfn_back #(
    parameter int NORMAL_FRAC_BITS = 14
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  tfn_pkg::cross_t   head,
    output logic              pop,
    output logic              out_valid,
    output tfn_pkg::tri_out_t out_data,
    input  logic              out_stall
);
    import tfn_pkg::*;

    localparam int NFB       = NORMAL_FRAC_BITS;
    localparam int MW        = CROSS_WIDTH;
    localparam int GROUPS    = (MW + 7) / 8;
    localparam int PADW      = GROUPS * 8;
    localparam int LZW       = $clog2(PADW);
    localparam int SQW       = 64;
    localparam int SQ_STEPS  = 32;
    localparam int ROOTW     = 31;
    localparam int DIV_STEPS = NFB + 1;
    localparam int DVW       = NFB + 33;
    localparam int QW        = NFB + 1;
    localparam int TOTAL     = 6 + SQ_STEPS + 1 + DIV_STEPS + 1;

    typedef struct packed {
        logic [2:0] sign;
        logic       deg;
        logic       last;
    } side_t;

    function automatic logic [2:0] lz8(input logic [7:0] b);
        logic [2:0] n;
        n = 3'd7;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                n = 3'(7 - i);
        end
        return n;
    endfunction

    logic                 be;
    logic [TOTAL-1:0]     valid_reg;

    // Magnitudes and leading-one search
    logic [MW-1:0]        m0_reg [3];
    logic [MW-1:0]        or0_reg;
    side_t                side0_reg;
    logic [PADW-1:0]      padded;
    logic [GROUPS-1:0]    nz1_reg;
    logic [2:0]           llz1_reg [GROUPS];
    logic [MW-1:0]        m1_reg [3];
    side_t                side1_reg;
    logic [LZW-1:0]       lz_next;
    logic                 deg_next;
    logic [LZW-1:0]       lz2_reg;
    logic [MW-1:0]        m2_reg [3];
    side_t                side2_reg;
    logic [MW-1:0]        shifted [3];
    logic [NORM_WIDTH-1:0] mn3_reg [3];
    side_t                side3_reg;
    logic [2*NORM_WIDTH-1:0] sq4_reg [3];
    logic [NORM_WIDTH-1:0] mn4_reg [3];
    side_t                side4_reg;

    // Square root pipeline, index 0 holds the sum of squares
    logic [SQW-1:0]       rem_reg  [SQ_STEPS+1];
    logic [SQW-1:0]       root_reg [SQ_STEPS+1];
    logic [NORM_WIDTH-1:0] mns_reg [SQ_STEPS+1][3];
    side_t                sides_reg [SQ_STEPS+1];

    // Division pipeline, index 0 holds the rounded numerators
    logic [DVW-1:0]       r_reg   [DIV_STEPS+1][3];
    logic [QW-1:0]        q_reg   [DIV_STEPS+1][3];
    logic [ROOTW-1:0]     len_reg [DIV_STEPS+1];
    side_t                sided_reg [DIV_STEPS+1];

    tri_out_t             out_reg;
    logic [QW-1:0]        q_sat [3];
    logic [31:0]          q_ext [3];
    logic [31:0]          q_sgn [3];

    assign be        = !valid_reg[TOTAL-1] || !out_stall;
    assign pop       = be && head_valid;
    assign out_valid = valid_reg[TOTAL-1];
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (be)
            valid_reg <= {valid_reg[TOTAL-2:0], head_valid};
    end

    assign padded = PADW'(or0_reg) << (PADW - MW);

    always_comb
    begin
        lz_next  = '0;
        deg_next = 1'b1;
        for (int g = GROUPS - 1; g >= 0; g--)
        begin
            if (nz1_reg[g])
            begin
                lz_next  = LZW'(g * 8) + LZW'(llz1_reg[g]);
                deg_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            shifted[i] = m2_reg[i] << lz2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (be)
        begin
            // Magnitudes keep the sign apart; the OR shares the top one bit.
            for (int i = 0; i < 3; i++)
                m0_reg[i] <= head.prod[i][MW-1] ? MW'(~head.prod[i] + 1'b1)
                                                : head.prod[i];
            or0_reg <= (head.prod[0][MW-1] ? MW'(~head.prod[0] + 1'b1) : head.prod[0])
                     | (head.prod[1][MW-1] ? MW'(~head.prod[1] + 1'b1) : head.prod[1])
                     | (head.prod[2][MW-1] ? MW'(~head.prod[2] + 1'b1) : head.prod[2]);
            side0_reg.sign <= {head.prod[2][MW-1], head.prod[1][MW-1],
                               head.prod[0][MW-1]};
            side0_reg.deg  <= 1'b0;
            side0_reg.last <= head.last;

            for (int g = 0; g < GROUPS; g++)
            begin
                nz1_reg[g]  <= |padded[PADW-1-8*g -: 8];
                llz1_reg[g] <= lz8(padded[PADW-1-8*g -: 8]);
            end
            m1_reg    <= m0_reg;
            side1_reg <= side0_reg;

            lz2_reg        <= lz_next;
            m2_reg         <= m1_reg;
            side2_reg.sign <= side1_reg.sign;
            side2_reg.last <= side1_reg.last;
            side2_reg.deg  <= deg_next;

            for (int i = 0; i < 3; i++)
                mn3_reg[i] <= shifted[i][MW-1 -: NORM_WIDTH];
            side3_reg <= side2_reg;

            for (int i = 0; i < 3; i++)
                sq4_reg[i] <= mn3_reg[i] * mn3_reg[i];
            mn4_reg   <= mn3_reg;
            side4_reg <= side3_reg;

            rem_reg[0]   <= SQW'(sq4_reg[0]) + SQW'(sq4_reg[1]) + SQW'(sq4_reg[2]);
            root_reg[0]  <= '0;
            mns_reg[0]   <= mn4_reg;
            sides_reg[0] <= side4_reg;
        end
    end

    // One root bit per stage, trial bit walking down from the top.
    for (genvar s = 1; s <= SQ_STEPS; s++)
    begin : g_sqrt
        localparam logic [SQW-1:0] BIT = SQW'(1) << (62 - 2 * (s - 1));
        logic [SQW-1:0] trial;
        assign trial = root_reg[s-1] + BIT;

        always_ff @(posedge clk)
        begin
            if (be)
            begin
                if (rem_reg[s-1] >= trial)
                begin
                    rem_reg[s]  <= rem_reg[s-1] - trial;
                    root_reg[s] <= (root_reg[s-1] >> 1) + BIT;
                end
                else
                begin
                    rem_reg[s]  <= rem_reg[s-1];
                    root_reg[s] <= root_reg[s-1] >> 1;
                end
                mns_reg[s]   <= mns_reg[s-1];
                sides_reg[s] <= sides_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (be)
        begin
            // Half the length is added so the quotient rounds half up.
            for (int i = 0; i < 3; i++)
            begin
                r_reg[0][i] <= (DVW'(mns_reg[SQ_STEPS][i]) << NFB)
                             + DVW'(root_reg[SQ_STEPS][ROOTW-1:1]);
                q_reg[0][i] <= '0;
            end
            len_reg[0]   <= root_reg[SQ_STEPS][ROOTW-1:0];
            sided_reg[0] <= sides_reg[SQ_STEPS];
        end
    end

    for (genvar s = 1; s <= DIV_STEPS; s++)
    begin : g_div
        localparam int K = DIV_STEPS - s;
        logic [DVW-1:0] dsub;
        assign dsub = DVW'(len_reg[s-1]) << K;

        always_ff @(posedge clk)
        begin
            if (be)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (r_reg[s-1][i] >= dsub)
                    begin
                        r_reg[s][i] <= r_reg[s-1][i] - dsub;
                        q_reg[s][i] <= q_reg[s-1][i] | (QW'(1) << K);
                    end
                    else
                    begin
                        r_reg[s][i] <= r_reg[s-1][i];
                        q_reg[s][i] <= q_reg[s-1][i];
                    end
                end
                len_reg[s]   <= len_reg[s-1];
                sided_reg[s] <= sided_reg[s-1];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            q_sat[i] = (q_reg[DIV_STEPS][i] > (QW'(1) << NFB)) ? (QW'(1) << NFB)
                                                               : q_reg[DIV_STEPS][i];
            q_ext[i] = 32'(q_sat[i]);
            q_sgn[i] = sided_reg[DIV_STEPS].sign[i] ? (~q_ext[i] + 32'd1) : q_ext[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (be)
        begin
            if (sided_reg[DIV_STEPS].deg)
            begin
                out_reg.normal_x <= '0;
                out_reg.normal_y <= '0;
                out_reg.normal_z <= '0;
            end
            else
            begin
                out_reg.normal_x <= q_sgn[0][OUT_WIDTH-1:0];
                out_reg.normal_y <= q_sgn[1][OUT_WIDTH-1:0];
                out_reg.normal_z <= q_sgn[2][OUT_WIDTH-1:0];
            end
            out_reg.degenerate  <= sided_reg[DIV_STEPS].deg;
            out_reg.last_normal <= sided_reg[DIV_STEPS].last;
        end
    end

endmodule

@@ rtl/core/triangle_face_normal.sv @@
// Throughput: one triangle per cycle unless stalled; the square root takes one stage per root bit
// and the division one stage per quotient bit, so a new item enters every cycle.
// A four-entry queue lets the front end keep taking items while the output stalls, until it fills.
// Reset clears all valid state; no result is pending after reset.
`timescale 1ns / 1ps

module triangle_face_normal #(
    parameter int NORMAL_FRAC_BITS = 14
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  tfn_pkg::tri_in_t  in_data,
    output logic              in_stall,
    output logic              out_valid,
    output tfn_pkg::tri_out_t out_data,
    input  logic              out_stall
);
    import tfn_pkg::*;

    logic   q_full;
    logic   push;
    cross_t push_data;
    logic   pop;
    logic   head_valid;
    cross_t head;

    tfn_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_data   (in_data),
        .in_stall  (in_stall),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    tfn_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    tfn_back #(
        .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_data   (out_data),
        .out_stall  (out_stall)
    );

endmodule
